// ===== design/r2bmp_pkg.sv =====
package r2bmp_pkg;

	// Field and register widths.
	localparam int DIM_W  = 13;
	localparam int COL_W  = 12;
	localparam int ROW_W  = 13;
	localparam int LINE_W = 14;
	localparam int PROD_W = DIM_W + LINE_W;
	localparam int IDX_W  = 6;

	// Largest usable image dimension; larger register values clamp to it.
	localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

	// Input action codes.
	localparam logic ACT_BEGIN = 1'b0;
	localparam logic ACT_PIXEL = 1'b1;

	// Configuration register indexes.
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd256;
	localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd192;

	// Header layout.
	localparam logic [IDX_W-1:0] HDR_LAST      = 6'd53;
	localparam logic [IDX_W-1:0] PIX_LAST_BASE = 6'd2;
	localparam logic [7:0]       HDR_BYTES     = 8'd54;
	localparam logic [7:0]       INFO_SIZE     = 8'd40;
	localparam logic [7:0]       BITS_PER_PIX  = 8'd24;
	localparam logic [7:0]       CHAR_B        = 8'h42;
	localparam logic [7:0]       CHAR_M        = 8'h4d;

	// Byte idx of the 54-byte file and info header.
	function automatic logic [7:0] hdr_byte(
		input logic [IDX_W-1:0] idx,
		input logic [31:0]      fsize,
		input logic [DIM_W-1:0] w,
		input logic [DIM_W-1:0] h
	);
		logic [7:0] b;
		case (idx)
			6'd0:    b = CHAR_B;
			6'd1:    b = CHAR_M;
			6'd2:    b = fsize[7:0];
			6'd3:    b = fsize[15:8];
			6'd4:    b = fsize[23:16];
			6'd5:    b = fsize[31:24];
			6'd10:   b = HDR_BYTES;
			6'd14:   b = INFO_SIZE;
			6'd18:   b = w[7:0];
			6'd19:   b = {3'b000, w[12:8]};
			6'd22:   b = h[7:0];
			6'd23:   b = {3'b000, h[12:8]};
			6'd26:   b = 8'd1;
			6'd28:   b = BITS_PER_PIX;
			default: b = 8'd0;
		endcase
		return b;
	endfunction

endpackage

// ===== design/rgb555_to_bmp24_encoder_core.sv =====
// Path of an item's first byte after its input transfer: the item register, then the output
// register, when the output is free.
// Throughput: one output byte per cycle while out_ready does not stall; a pixel gives 3 bytes
// plus width mod 4 padding bytes at a row end, a begin item 54 bytes, all through the single byte-wide output register.
// A new item is taken in the cycle the previous item's last byte moves to the output register.
// Reset (arst_n low, asynchronous): counters cleared, width 256, height 192, no output pending.
module rgb555_to_bmp24_encoder_core
	import r2bmp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// configuration writes
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [DIM_W-1:0] cfg_data,
	// input items
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             action,
	input  logic [15:0]      pixel,
	// output bytes
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       data_byte,
	output logic             last_of_run,
	output logic             end_of_image
);

	// Configuration registers, always writable.
	logic [DIM_W-1:0] width_q, height_q;

	// Image position: pixels taken in the current row, rows finished.
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	// Item register: the item whose bytes are being sent out.
	logic              busy_s1;
	logic              hdr_s1;
	logic [14:0]       pix_s1;
	logic [DIM_W-1:0]  w_s1, h_s1;
	logic [LINE_W-1:0] line_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [IDX_W-1:0]  last_idx_s1;
	logic              end_s1;

	// File size, two registered steps behind the item register.
	// Byte 2 of the header leaves only after both steps hold the new item's size.
	logic [PROD_W-1:0] prod_q;
	logic [31:0]       fsize_q;

	// Output register.
	logic       out_valid_q;
	logic [7:0] data_q;
	logic       last_q, eoi_q;

	// Effective dimensions after clamping.
	logic [DIM_W-1:0] w_eff, h_eff;
	assign w_eff = (width_q  > MAX_DIM) ? MAX_DIM : width_q;
	assign h_eff = (height_q > MAX_DIM) ? MAX_DIM : height_q;

	// Handshakes.
	logic in_xfer, is_begin, pix_drop, load;
	logic adv, byte_last;

	assign cfg_ready = 1'b1;
	assign adv       = busy_s1 && (!out_valid_q || out_ready);
	assign byte_last = (idx_s1 == last_idx_s1);
	assign in_ready  = !busy_s1 || (adv && byte_last);
	assign in_xfer   = in_valid && in_ready;
	assign is_begin  = (action == ACT_BEGIN);
	// Pixels of an empty or finished image give no bytes.
	assign pix_drop  = (w_eff == '0) || (row_q >= h_eff);
	assign load      = in_xfer && (is_begin || !pix_drop);

	// Pixel position bookkeeping. A full 4096-wide row wraps the column count to zero.
	logic [COL_W-1:0] col_nxt;
	logic             row_end, img_end;
	logic [1:0]       pad;
	logic [ROW_W:0]   row_inc;
	assign col_nxt = col_q + 1'b1;
	assign row_end = (col_nxt == '0) || ({1'b0, col_nxt} >= w_eff);
	assign row_inc = {1'b0, row_q} + 1'b1;
	assign img_end = row_end && (row_inc >= {1'b0, h_eff});
	assign pad     = row_end ? w_eff[1:0] : 2'd0;

	// Row stride in bytes: 3W rounded up to a multiple of four.
	logic [LINE_W-1:0] line_nxt;
	assign line_nxt = ((LINE_W'(w_eff) << 1) + LINE_W'(w_eff) + LINE_W'(3)) & ~LINE_W'(3);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= WIDTH_RST;
			height_q    <= HEIGHT_RST;
			col_q       <= '0;
			row_q       <= '0;
			busy_s1     <= 1'b0;
			idx_s1      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_IMAGE_WIDTH:  width_q  <= cfg_data;
					REG_IMAGE_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end

			if (in_xfer) begin
				if (is_begin) begin
					col_q <= '0;
					row_q <= '0;
				end else if (!pix_drop) begin
					if (row_end) begin
						col_q <= '0;
						row_q <= row_inc[ROW_W-1:0];
					end else begin
						col_q <= col_nxt;
					end
				end
			end

			if (load) begin
				busy_s1 <= 1'b1;
				idx_s1  <= '0;
			end else if (adv) begin
				if (byte_last)
					busy_s1 <= 1'b0;
				idx_s1 <= idx_s1 + 1'b1;
			end

			if (adv)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Item register payload.
	always_ff @(posedge clk) begin
		if (load) begin
			hdr_s1  <= is_begin;
			pix_s1  <= pixel[14:0];
			w_s1    <= w_eff;
			h_s1    <= h_eff;
			line_s1 <= line_nxt;
			if (is_begin) begin
				last_idx_s1 <= HDR_LAST;
				end_s1      <= (w_eff == '0) || (h_eff == '0);
			end else begin
				last_idx_s1 <= PIX_LAST_BASE + IDX_W'(pad);
				end_s1      <= img_end;
			end
		end
	end

	// File size = 54 + H * stride.
	always_ff @(posedge clk) begin
		prod_q  <= h_s1 * line_s1;
		fsize_q <= 32'(prod_q) + 32'(HDR_BYTES);
	end

	// Byte for the current index.
	logic [7:0] byte_nxt;
	always_comb begin
		if (hdr_s1) begin
			byte_nxt = hdr_byte(idx_s1, fsize_q, w_s1, h_s1);
		end else begin
			case (idx_s1)
				6'd0:    byte_nxt = {pix_s1[14:10], 3'b000};
				6'd1:    byte_nxt = {pix_s1[9:5], 3'b000};
				6'd2:    byte_nxt = {pix_s1[4:0], 3'b000};
				default: byte_nxt = 8'd0;   // row padding
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_q <= byte_nxt;
			last_q <= byte_last;
			eoi_q  <= byte_last && end_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign data_byte    = data_q;
	assign last_of_run  = last_q;
	assign end_of_image = eoi_q;

endmodule

// ===== design/r2bmp_checker.sv =====
module r2bmp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] data_byte,
	input logic       last_of_run,
	input logic       end_of_image
);

	// A stalled byte holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_byte)
			&& $stable(last_of_run) && $stable(end_of_image))
		else $error("output byte changed under stall");

	// The file's final byte also closes its run.
	a_eoi_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_image |-> last_of_run)
		else $error("end_of_image without last_of_run");

	// Bytes of one run leave without gaps.
	a_run_dense: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid)
		else $error("gap inside a run");

	// Configuration writes are never stalled.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind rgb555_to_bmp24_encoder_core r2bmp_checker u_r2bmp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.data_byte    (data_byte),
	.last_of_run  (last_of_run),
	.end_of_image (end_of_image)
);
